>>> rtl/adf_pkg.sv
// Shared types, constants and codes for the ADPCM frame decoder.
package adf_pkg;

    localparam int CHANNELS          = 2;
    localparam int SAMPLES_PER_FRAME = 14;
    localparam int COEF_REGS         = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int NIBBLE_W          = 56;
    localparam int COUNT_W           = 4;
    localparam int PCM_W             = 16;
    localparam int ACC_W             = 34;
    localparam int FRAC_W            = 11;
    localparam int STEP_W            = 20;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QCOUNT_W          = 2;

    typedef struct packed {
        logic                chan_id;
        logic [7:0]          header_byte;
        logic [NIBBLE_W-1:0] nibble_bytes;
        logic [COUNT_W-1:0]  sample_count;
        logic                stream_start;
    } frame_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    out_chan;
        logic                    last_of_frame;
        logic                    bad_index;
    } sample_t;

    typedef enum logic {
        CMD_DECODE,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic                    chan;
        logic                    start;
        logic [3:0]              shift_exp;
        logic [COUNT_W-1:0]      count;
        logic signed [PCM_W-1:0] coef1;
        logic signed [PCM_W-1:0] coef2;
        logic [NIBBLE_W-1:0]     data;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

>>> rtl/adf_front.sv
// Front end: coefficient registers, request classification and command build.
module adf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  adf_pkg::frame_t                 frame,
    input  logic                            cfg_write,
    input  logic [adf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            queue_full,
    output logic                            cmd_push,
    output adf_pkg::cmd_t                   cmd
);
    import adf_pkg::*;

    logic [CFG_DATA_W-1:0] coef_reg [COEF_REGS];
    logic [CFG_DATA_W-1:0] coef_word;
    logic [3:0]            pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    assign pair      = frame.header_byte[7:4];
    assign coef_word = coef_reg[{frame.chan_id, pair[2:1]}];
    assign cmd_push  = push && !queue_full;

    always_comb
    begin
        cmd.kind      = pair[3] ? CMD_BAD : CMD_DECODE;
        cmd.chan      = frame.chan_id;
        cmd.start     = frame.stream_start;
        cmd.shift_exp = frame.header_byte[3:0];
        cmd.count     = (frame.sample_count > COUNT_W'(SAMPLES_PER_FRAME)) ?
                        COUNT_W'(SAMPLES_PER_FRAME) : frame.sample_count;
        cmd.coef1     = pair[0] ? coef_word[47:32] : coef_word[15:0];
        cmd.coef2     = pair[0] ? coef_word[63:48] : coef_word[31:16];
        cmd.data      = frame.nibble_bytes;
    end

endmodule

>>> rtl/adf_cmd_queue.sv
// Two-entry command queue between the front end and the decode engine.
module adf_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  adf_pkg::cmd_t entry,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output adf_pkg::cmd_t head
);
    import adf_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [QCOUNT_W-1:0] cnt_reg;
    logic [QCOUNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> rtl/adf_back.sv
// Decode engine: per-channel history, result queue; one sample per cycle unless full
module adf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_empty,
    input  adf_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    input  logic             pop,
    output logic             empty,
    output adf_pkg::sample_t sample
);
    import adf_pkg::*;

    back_state_t             state_reg;
    back_state_t             state_next;
    cmd_t                    cur_reg;
    logic [COUNT_W-1:0]      idx_reg;
    logic signed [PCM_W-1:0] h1_reg [CHANNELS];
    logic signed [PCM_W-1:0] h2_reg [CHANNELS];

    sample_t                 ob_mem_reg [QUEUE_DEPTH];
    logic                    ob_wr_reg;
    logic                    ob_rd_reg;
    logic [QCOUNT_W-1:0]     ob_cnt_reg;
    logic [QCOUNT_W-1:0]     ob_cnt_next;
    logic                    ob_full;
    logic                    ob_pop;

    logic                    emit;
    logic                    last;
    logic                    skip_cmd;
    logic signed [PCM_W-1:0] h1;
    logic signed [PCM_W-1:0] h2;
    logic signed [31:0]      prod1;
    logic signed [31:0]      prod2;
    logic signed [STEP_W-1:0] step;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-FRAC_W-1:0] quot;
    logic signed [PCM_W-1:0] sat;
    sample_t                 result;

    // A decode command with no samples needs no run state; start clears history.
    assign skip_cmd = (cmd.kind == CMD_DECODE) && (cmd.count == '0);
    assign last     = (idx_reg == cur_reg.count - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && !skip_cmd)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (emit && ((cur_reg.kind == CMD_BAD) || last))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop = 1'b0;
        emit    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_pop = !cmd_empty;
            end
            BK_RUN:
            begin
                emit = !ob_full;
            end
            default:
            begin
                cmd_pop = 1'b0;
                emit    = 1'b0;
            end
        endcase
    end

    // Sample datapath: the residual is the two's complement value of the nibble.
    assign h1    = h1_reg[cur_reg.chan];
    assign h2    = h2_reg[cur_reg.chan];
    assign prod1 = cur_reg.coef1 * h1;
    assign prod2 = cur_reg.coef2 * h2;
    assign step  = STEP_W'($signed(cur_reg.data[NIBBLE_W-1 -: 4])) <<< cur_reg.shift_exp;
    assign acc   = (ACC_W'(step) <<< FRAC_W) + ACC_W'(1024) + ACC_W'(prod1) + ACC_W'(prod2);
    assign quot  = acc[ACC_W-1:FRAC_W];

    always_comb
    begin
        if (quot > (ACC_W-FRAC_W)'(32767))
        begin
            sat = 16'sh7FFF;
        end
        else if (quot < -(ACC_W-FRAC_W)'(32768))
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = quot[PCM_W-1:0];
        end
    end

    always_comb
    begin
        result.out_chan = cur_reg.chan;
        if (cur_reg.kind == CMD_BAD)
        begin
            result.pcm_sample    = '0;
            result.last_of_frame = 1'b1;
            result.bad_index     = 1'b1;
        end
        else
        begin
            result.pcm_sample    = sat;
            result.last_of_frame = last;
            result.bad_index     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop)
            begin
                idx_reg <= '0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                h1_reg[i] <= '0;
                h2_reg[i] <= '0;
            end
        end
        else if (cmd_pop && (cmd.kind == CMD_DECODE) && cmd.start)
        begin
            h1_reg[cmd.chan] <= '0;
            h2_reg[cmd.chan] <= '0;
        end
        else if (emit && (cur_reg.kind == CMD_DECODE))
        begin
            h1_reg[cur_reg.chan] <= sat;
            h2_reg[cur_reg.chan] <= h1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        else if (emit)
        begin
            cur_reg.data <= cur_reg.data << 4;
        end
    end

    // Result queue: a finished sample waits here until pop takes it.
    assign ob_full = (ob_cnt_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign empty   = (ob_cnt_reg == '0);
    assign ob_pop  = pop && !empty;
    assign sample  = ob_mem_reg[ob_rd_reg];

    always_comb
    begin
        ob_cnt_next = ob_cnt_reg;
        if (emit && !ob_pop)
        begin
            ob_cnt_next = ob_cnt_reg + 1'b1;
        end
        else if (ob_pop && !emit)
        begin
            ob_cnt_next = ob_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                ob_wr_reg <= ~ob_wr_reg;
            end
            if (ob_pop)
            begin
                ob_rd_reg <= ~ob_rd_reg;
            end
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_mem_reg[ob_wr_reg] <= result;
        end
    end

endmodule

>>> rtl/dsp_adpcm_frame_decoder_unit.sv
// Top level of the two-channel ADPCM frame decoder.
// Each request is one 8-byte frame; it produces one signed 16-bit sample per clock
// while the result queue has room. The decode engine first loads the command, then
// decodes the samples one by one, each fed back through the two history samples;
// a frame with a bad coefficient index gives one error result and a frame with a zero
// count gives none. A two-entry command queue lets new frames be taken while a frame
// is being decoded, and a two-entry result queue holds samples while pop is low. The
// user must write coefficient registers only while idle; the block does not check it.
module dsp_adpcm_frame_decoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  adf_pkg::frame_t                 frame,
    input  logic                            cfg_write,
    input  logic [adf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            empty,
    input  logic                            pop,
    output adf_pkg::sample_t                sample
);
    import adf_pkg::*;

    logic cmd_push;
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_head;

    adf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .frame      (frame),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    adf_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .entry (cmd_in),
        .pop   (cmd_pop),
        .full  (full),
        .empty (cmd_empty),
        .head  (cmd_head)
    );

    adf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .sample    (sample)
    );

endmodule

>>> rtl/adf_checker.sv
// Port-level assertions for the ADPCM frame decoder and their binding.
module adf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input adf_pkg::frame_t                 frame,
    input logic                            cfg_write,
    input logic [adf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [adf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                            empty,
    input logic                            pop,
    input adf_pkg::sample_t                sample
);
    import adf_pkg::*;

    // An error result carries a zero sample and closes its frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sample.bad_index) |-> (sample.pcm_sample == '0 && sample.last_of_frame))
    else $error("error result with non-zero sample or open frame");

    // A waiting result stays on the ports until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sample)))
    else $error("waiting result changed before it was taken");

    // The input side can only fill up after a request has been pushed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
    else $error("full rose without a request");

endmodule

bind dsp_adpcm_frame_decoder_unit adf_checker u_checker (.*);

>>> tb/dsp_adpcm_frame_decoder_unit_tb.sv
// Self-checking testbench for the two-channel ADPCM frame decoder.
`timescale 1ns / 1ps

module dsp_adpcm_frame_decoder_unit_tb;

    import adf_pkg::*;

    localparam int SETTLE_CYCLES    = 24;
    localparam int STALL_LIMIT      = 3000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 5;
    localparam int RANDOM_PER_PHASE = 52;
    localparam int DIR_ROWS         = 20;

    typedef enum int {
        PAT_KEEP,
        PAT_ZERO,
        PAT_MAX,
        PAT_MIN,
        PAT_ONES,
        PAT_MIXED,
        PAT_TYPICAL,
        PAT_RANDOM
    } coef_pat_t;

    typedef struct {
        coef_pat_t          pat;
        logic               chan;
        logic [7:0]         hdr;
        logic [55:0]        data;
        logic [3:0]         cnt;
        logic               start;
        bit                 typed;
        logic signed [15:0] want_pcm;
        logic               want_bad;
    } dir_row_t;

    // Rows marked as typed carry their single expected sample; the rest go through
    // the decoder model.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{PAT_KEEP,  1'b0, 8'h0F, 56'h70000000000000, 4'd1,  1'b1, 1'b1, 16'h7FFF, 1'b0},
        '{PAT_KEEP,  1'b1, 8'h0F, 56'h80000000000000, 4'd1,  1'b0, 1'b1, 16'h8000, 1'b0},
        '{PAT_KEEP,  1'b0, 8'h00, 56'hF0000000000000, 4'd1,  1'b0, 1'b1, 16'hFFFF, 1'b0},
        '{PAT_KEEP,  1'b1, 8'h03, 56'h10000000000000, 4'd1,  1'b0, 1'b1, 16'h0008, 1'b0},
        '{PAT_KEEP,  1'b0, 8'h80, 56'h00000000000000, 4'd14, 1'b1, 1'b1, 16'h0000, 1'b1},
        '{PAT_KEEP,  1'b1, 8'hFF, 56'hFFFFFFFFFFFFFF, 4'd0,  1'b0, 1'b1, 16'h0000, 1'b1},
        '{PAT_KEEP,  1'b0, 8'h7F, 56'hFFFFFFFFFFFFFF, 4'd1,  1'b0, 1'b1, 16'h8000, 1'b0},
        '{PAT_KEEP,  1'b0, 8'h00, 56'h12345670000000, 4'd0,  1'b1, 1'b0, 16'h0000, 1'b0},
        '{PAT_KEEP,  1'b1, 8'h12, 56'h0123456789ABCD, 4'd15, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{PAT_KEEP,  1'b0, 8'h44, 56'h89ABCDEF012345, 4'd14, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{PAT_MAX,   1'b0, 8'h00, 56'h77777777777777, 4'd14, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{PAT_KEEP,  1'b1, 8'h74, 56'h88888888888888, 4'd14, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{PAT_MIN,   1'b0, 8'h31, 56'h7F7F7F7F7F7F7F, 4'd14, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{PAT_KEEP,  1'b0, 8'h00, 56'h00000000000000, 4'd0,  1'b1, 1'b0, 16'h0000, 1'b0},
        '{PAT_KEEP,  1'b0, 8'h60, 56'h12345670000000, 4'd5,  1'b0, 1'b0, 16'h0000, 1'b0},
        '{PAT_MIXED, 1'b1, 8'h2A, 56'h77777777777777, 4'd14, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{PAT_KEEP,  1'b1, 8'h90, 56'h77777777777777, 4'd14, 1'b1, 1'b1, 16'h0000, 1'b1},
        '{PAT_KEEP,  1'b1, 8'h20, 56'h00000000000000, 4'd14, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{PAT_ONES,  1'b0, 8'h5B, 56'hFEDCBA98765432, 4'd14, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{PAT_ZERO,  1'b1, 8'h40, 56'h50000000000000, 4'd1,  1'b0, 1'b1, 16'h0005, 1'b0}
    };

    coef_pat_t phase_pats [RANDOM_PHASES] = '{
        PAT_TYPICAL, PAT_RANDOM, PAT_TYPICAL, PAT_MIN, PAT_TYPICAL
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    frame_t                req_frame = '0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    sample_t               dec_sample;

    logic [CFG_DATA_W-1:0] coef_word [COEF_REGS];
    logic signed [15:0]    hist_one [CHANNELS];
    logic signed [15:0]    hist_two [CHANNELS];
    sample_t               pending_samples [$];

    int  fail_count = 0;
    int  frames_sent = 0;
    int  bad_frames = 0;
    int  samples_checked = 0;
    int  cfg_writes = 0;
    bit  calm = 1'b0;
    bit  long_hold = 1'b0;

    dsp_adpcm_frame_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .frame     (req_frame),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .sample    (dec_sample)
    );

    function automatic void decode_frame(input frame_t f, ref sample_t res [$]);
        logic               ch;
        logic [3:0]         shift;
        logic [3:0]         pair;
        logic [3:0]         count;
        logic [63:0]        word;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic signed [3:0]  nib;
        longint             h1;
        longint             h2;
        longint             k1;
        longint             k2;
        longint             nv;
        longint             acc;
        longint             s;
        sample_t            r;
        res.delete();
        ch = f.chan_id;
        shift = f.header_byte[3:0];
        pair = f.header_byte[7:4];
        if (pair > 4'd7)
        begin
            r.pcm_sample = '0;
            r.out_chan = ch;
            r.last_of_frame = 1'b1;
            r.bad_index = 1'b1;
            res.insert(res.size(), r);
            return;
        end
        if (f.stream_start)
        begin
            hist_one[ch] = '0;
            hist_two[ch] = '0;
        end
        count = (f.sample_count > SAMPLES_PER_FRAME) ? 4'(SAMPLES_PER_FRAME)
                                                     : f.sample_count;
        word = coef_word[{ch, pair[2:1]}];
        c1 = pair[0] ? word[47:32] : word[15:0];
        c2 = pair[0] ? word[63:48] : word[31:16];
        k1 = c1;
        k2 = c2;
        h1 = hist_one[ch];
        h2 = hist_two[ch];
        for (int i = 0; i < count; i++)
        begin
            nib = f.nibble_bytes[52 - 4 * i +: 4];
            nv = nib;
            acc = (nv <<< shift) * 2048 + 1024 + k1 * h1 + k2 * h2;
            s = acc >>> 11;
            if (s > 32767)
                s = 32767;
            else if (s < -32768)
                s = -32768;
            h2 = h1;
            h1 = s;
            r.pcm_sample = s[15:0];
            r.out_chan = ch;
            r.last_of_frame = (i == count - 1);
            r.bad_index = 1'b0;
            res.insert(res.size(), r);
        end
        hist_one[ch] = h1[15:0];
        hist_two[ch] = h2[15:0];
    endfunction

    function automatic logic [63:0] coef_word_for(coef_pat_t pat);
        logic [63:0] w;
        case (pat)
            PAT_MAX:   w = {4{16'h7FFF}};
            PAT_MIN:   w = {4{16'h8000}};
            PAT_ONES:  w = '1;
            PAT_MIXED: w = {2{16'h8000, 16'h7FFF}};
            PAT_TYPICAL:
            begin
                for (int k = 0; k < 4; k++)
                    w[16 * k +: 16] = 16'($urandom_range(0, 8191) - 4096);
            end
            PAT_RANDOM: w = {$urandom, $urandom};
            default:   w = '0;
        endcase
        return w;
    endfunction

    function automatic frame_t random_frame();
        frame_t      f;
        logic [63:0] bits;
        int          pick;
        bits = {$urandom, $urandom};
        f.chan_id = 1'($urandom_range(0, 1));
        f.header_byte[7:4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                         : 4'($urandom_range(0, 7));
        f.header_byte[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(0, 4));
        f.nibble_bytes = bits[55:0];
        pick = $urandom_range(0, 19);
        if (pick == 0)
            f.sample_count = 4'd0;
        else if (pick == 1)
            f.sample_count = 4'd15;
        else if (pick < 6)
            f.sample_count = 4'd14;
        else
            f.sample_count = 4'($urandom_range(1, 13));
        f.stream_start = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    task automatic check_sample(sample_t got);
        sample_t want;
        if (pending_samples.size() == 0)
        begin
            $error("unexpected result: pcm_sample %0d, out_chan %0d", got.pcm_sample,
                   got.out_chan);
            fail_count++;
        end
        else
        begin
            want = pending_samples.pop_front();
            samples_checked++;
            if (got.pcm_sample !== want.pcm_sample)
            begin
                $error("pcm_sample: expected %0d, got %0d", want.pcm_sample, got.pcm_sample);
                fail_count++;
            end
            if (got.out_chan !== want.out_chan)
            begin
                $error("out_chan: expected %0d, got %0d", want.out_chan, got.out_chan);
                fail_count++;
            end
            if (got.last_of_frame !== want.last_of_frame)
            begin
                $error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
                       got.last_of_frame);
                fail_count++;
            end
            if (got.bad_index !== want.bad_index)
            begin
                $error("bad_index: expected %0d, got %0d", want.bad_index, got.bad_index);
                fail_count++;
            end
        end
    endtask

    task automatic send_frame(frame_t f, bit typed, sample_t want);
        sample_t res [$];
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push <= 1'b1;
        req_frame <= f;
        do @(posedge clk); while (full);
        decode_frame(f, res);
        if (typed)
            pending_samples.insert(pending_samples.size(), want);
        else
            foreach (res[i])
                pending_samples.insert(pending_samples.size(), res[i]);
        frames_sent++;
        if (f.header_byte[7:4] > 4'd7)
            bad_frames++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge clk); while (pending_samples.size() != 0);
    endtask

    // Coefficients change only once the decoder has gone idle, including frames
    // with a zero count that leave nothing in the result queue.
    task automatic load_coefs(coef_pat_t pat);
        logic [63:0] w;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int r = 0; r < COEF_REGS; r++)
        begin
            w = coef_word_for(pat);
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data <= w;
            coef_word[r] = w;
            @(posedge clk);
            cfg_writes++;
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_sample(dec_sample);
            if (long_hold)
            begin
                long_hold = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        frame_t f;
        for (int r = 0; r < COEF_REGS; r++)
            coef_word[r] = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            hist_one[c] = '0;
            hist_two[c] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].pat != PAT_KEEP)
                load_coefs(dir_rows[i].pat);
            f.chan_id = dir_rows[i].chan;
            f.header_byte = dir_rows[i].hdr;
            f.nibble_bytes = dir_rows[i].data;
            f.sample_count = dir_rows[i].cnt;
            f.stream_start = dir_rows[i].start;
            send_frame(f, dir_rows[i].typed,
                       {dir_rows[i].want_pcm, dir_rows[i].chan, 1'b1, dir_rows[i].want_bad});
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_coefs(phase_pats[ph]);
            calm = (ph == RANDOM_PHASES - 1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // The receiver stops taking samples for a long stretch so that
                // the decoder backs up and refuses further requests.
                if (ph == 1 && n == 10)
                    long_hold = 1'b1;
                if (ph == 2 && n == 20)
                    drain_results();
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d frames (%0d directed, %0d with a bad coefficient index)",
                 frames_sent, DIR_ROWS, bad_frames);
        $display("checked %0d samples over %0d register writes", samples_checked, cfg_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
